// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the design files of the bit run tracker.
// Depends on nothing; the checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent holds in a cycle, so the consequent holds in the same cycle.
`define CHK_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in a cycle, so the consequent holds in the next cycle.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CHK_SAME(lbl, clk, rstn, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- hdl/lbrt_pkg.sv -----
// Package of the bit run tracker: widths, controller states, command and
// status structs, and the seven-segment encoding. Depends on nothing.
package lbrt_pkg;

  // Width of the input word field and default width of the examined word.
  localparam int IN_W           = 32;
  localparam int WORD_BITS_DEF  = 32;

  // Run lengths and maxima are six bits wide and saturate.
  localparam int RUN_W          = 6;
  localparam logic [RUN_W-1:0] RUN_MAX = 6'd63;

  // Packed result payload: 66 field bits rounded up to whole bytes.
  localparam int OUT_W          = 72;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lbrt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } lbrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } lbrt_sts_t;

  // Segment pattern of one decimal digit, bit 0 = segment a.
  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'b0011_1111;
      4'd1:    s = 8'b0000_0110;
      4'd2:    s = 8'b0101_1011;
      4'd3:    s = 8'b0100_1111;
      4'd4:    s = 8'b0110_0110;
      4'd5:    s = 8'b0110_1101;
      4'd6:    s = 8'b0111_1101;
      4'd7:    s = 8'b0000_0111;
      4'd8:    s = 8'b0111_1111;
      4'd9:    s = 8'b0110_0111;
      default: s = 8'b0000_0000;
    endcase
    return s;
  endfunction

  // Tens pattern in the upper byte, units pattern in the lower byte.
  // The value stays below 64, so the tens digit comes from a few compares.
  function automatic logic [15:0] seg_pair(input logic [RUN_W-1:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    if (v >= 6'd60)      tens = 4'd6;
    else if (v >= 6'd50) tens = 4'd5;
    else if (v >= 6'd40) tens = 4'd4;
    else if (v >= 6'd30) tens = 4'd3;
    else if (v >= 6'd20) tens = 4'd2;
    else if (v >= 6'd10) tens = 4'd1;
    else                 tens = 4'd0;
    units = {1'b0, v} - ({3'd0, tens} * 7'd10);
    return {seg_digit(tens), seg_digit(units[3:0])};
  endfunction

endpackage

// ----- hdl/lbrt_ctrl.sv -----
// Controller of the bit run tracker: accepts an item, scans until every run vector
// is empty or the item is a terminator, then commits the result. Depends on lbrt_pkg.
module lbrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lbrt_pkg::lbrt_sts_t sts,
  output lbrt_pkg::lbrt_cmd_t cmd
);
  import lbrt_pkg::*;

  lbrt_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake.
  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: begin
        cmd.step  = !sts.scan_done;
      end
      ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/lbrt_dpath.sv -----
// Datapath of the bit run tracker: four shift-and-AND run vectors with
// counters, the running maxima and the result register. Depends on lbrt_pkg.
module lbrt_dpath #(
  parameter int WORD_BITS = lbrt_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lbrt_pkg::IN_W-1:0] in_word,
  input  lbrt_pkg::lbrt_cmd_t       cmd,
  output lbrt_pkg::lbrt_sts_t       sts,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  output logic [lbrt_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import lbrt_pkg::*;

  localparam int CP_W = (WORD_BITS < IN_W) ? WORD_BITS : IN_W;
  localparam int NV   = 4;

  // Vector order: ones, zeros, alternating ones, alternating zeros.
  logic [WORD_BITS-1:0] vec_r   [NV];
  logic [WORD_BITS-1:0] vec_nxt [NV];
  logic [RUN_W-1:0]     cnt_r   [NV];
  logic [RUN_W-1:0]     cnt_nxt [NV];
  logic                 zero_r, zero_nxt;

  logic [WORD_BITS-1:0] word_w;
  logic [WORD_BITS-1:0] alt_pat;
  logic [WORD_BITS-1:0] alt_w;

  logic [RUN_W-1:0] best_ones_r, best_zeros_r, best_alt_r;
  logic [RUN_W-1:0] best_ones_nxt, best_zeros_nxt, best_alt_nxt;
  logic [RUN_W-1:0] new_ones, new_zeros, new_alt, run_alt;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic all_empty;

  // Input word cut or zero-extended to the examined width; 0101...01 pattern.
  always_comb begin
    word_w = '0;
    word_w[CP_W-1:0] = in_word[CP_W-1:0];
    for (int i = 0; i < WORD_BITS; i++) begin
      alt_pat[i] = ~i[0];
    end
    alt_w = word_w ^ alt_pat;
  end

  // Load or shorten each run vector by one bit per step and count the steps.
  always_comb begin
    zero_nxt = zero_r;
    for (int k = 0; k < NV; k++) begin
      vec_nxt[k] = vec_r[k];
      cnt_nxt[k] = cnt_r[k];
    end
    if (cmd.load) begin
      zero_nxt   = (word_w == '0);
      vec_nxt[0] = word_w;
      vec_nxt[1] = ~word_w;
      vec_nxt[2] = alt_w;
      vec_nxt[3] = ~alt_w;
      for (int k = 0; k < NV; k++) begin
        cnt_nxt[k] = '0;
      end
    end else if (cmd.step) begin
      for (int k = 0; k < NV; k++) begin
        if (vec_r[k] != '0) begin
          vec_nxt[k] = vec_r[k] & (vec_r[k] >> 1);
          cnt_nxt[k] = (cnt_r[k] == RUN_MAX) ? cnt_r[k] : cnt_r[k] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= zero_nxt;
    for (int k = 0; k < NV; k++) begin
      vec_r[k] <= vec_nxt[k];
      cnt_r[k] <= cnt_nxt[k];
    end
  end

  // Scan ends when every vector is empty; a terminator needs no scan.
  always_comb begin
    all_empty = 1'b1;
    for (int k = 0; k < NV; k++) begin
      if (vec_r[k] != '0) all_empty = 1'b0;
    end
    sts.scan_done = all_empty || zero_r;
    sts.out_free  = !out_valid_r || out_tready;
  end

  // New maxima; a terminator leaves them as they are.
  always_comb begin
    run_alt   = (cnt_r[2] > cnt_r[3]) ? cnt_r[2] : cnt_r[3];
    new_ones  = best_ones_r;
    new_zeros = best_zeros_r;
    new_alt   = best_alt_r;
    if (!zero_r) begin
      if (cnt_r[0] > best_ones_r)  new_ones  = cnt_r[0];
      if (cnt_r[1] > best_zeros_r) new_zeros = cnt_r[1];
      if (run_alt  > best_alt_r)   new_alt   = run_alt;
    end
  end

  // Commit: write the result and update or clear the maxima.
  always_comb begin
    best_ones_nxt  = best_ones_r;
    best_zeros_nxt = best_zeros_r;
    best_alt_nxt   = best_alt_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (cmd.commit) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = zero_r;
      out_data_nxt   = {6'd0, seg_pair(new_alt), seg_pair(new_zeros),
                        seg_pair(new_ones), new_alt, new_zeros, new_ones};
      best_ones_nxt  = zero_r ? '0 : new_ones;
      best_zeros_nxt = zero_r ? '0 : new_zeros;
      best_alt_nxt   = zero_r ? '0 : new_alt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_ones_r  <= '0;
      best_zeros_r <= '0;
      best_alt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      best_ones_r  <= best_ones_nxt;
      best_zeros_r <= best_zeros_nxt;
      best_alt_r   <= best_alt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hdl/longest_bit_run_tracker.sv -----
// Longest bit run tracker: one item in flight. The shift-and-AND scan of an
// item goes on until the longest run of either value in the plain or the
// alternating word (at most WORD_BITS bits) is used up; a terminator item
// needs no scan. A new item is accepted only once the last result has been
// committed, so a result stalled by out_tready delays the next one.
// Synchronous active-low reset clears the maxima and empties the result slot.
`include "assert_macros.svh"

module longest_bit_run_tracker #(
  parameter int WORD_BITS = lbrt_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [31:0] word
  input  logic [lbrt_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [5:0] max_ones_run, [11:6] max_zeros_run, [17:12] max_alt_run,
  // [49:18] low_display, [65:50] high_display, [71:66] zero fill
  output logic [lbrt_pkg::OUT_W-1:0] out_tdata,
  // list_done
  output logic                       out_tlast
);
  import lbrt_pkg::*;

  lbrt_cmd_t cmd;
  lbrt_sts_t sts;

  // Sequencer.
  lbrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Run vectors, maxima and result register.
  lbrt_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Checks on the controller and datapath cooperation.
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accept")
  `CHK_SAME(a_commit_free, clk, rst_n, cmd.commit, sts.out_free, "result overwritten")
  `CHK_SAME(a_step_scan, clk, rst_n, cmd.step, !sts.scan_done, "step after scan end")
  `CHK_SAME(a_load_accept, clk, rst_n, cmd.load, in_tvalid && in_tready, "load without accept")

endmodule
